// File: rtl/fpg_pkg.sv
// Shared types and constants for the fern point generator.
// Holds the sequencer state type, map codes, the generator constants and the
// fixed-point map coefficients. No dependencies.
package fpg_pkg;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 64;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCALE    = 2'd0;
    localparam logic [1:0] CFG_X_OFFSET = 2'd1;
    localparam logic [1:0] CFG_Y_OFFSET = 2'd2;

    localparam logic [30:0] SCALE_RESET    = 31'd3276800;
    localparam logic [31:0] X_OFFSET_RESET = 32'd26214400;
    localparam logic [31:0] Y_OFFSET_RESET = 32'd0;

    // Linear congruential generator.
    localparam logic [30:0] LCG_MUL  = 31'd1103515245;
    localparam logic [30:0] LCG_ADD  = 31'd12345;
    localparam logic [30:0] LCG_SEED = 31'd42;

    // Map choice thresholds: 0.01, 0.86 and 0.93 of 2^31-1.
    localparam logic [30:0] TH_STEM = 31'd21474837;
    localparam logic [30:0] TH_MAIN = 31'd1846835937;
    localparam logic [30:0] TH_LEFT = 31'd1997159792;

    // Map coefficients in Q8.24, rounded to nearest.
    localparam logic signed [MUL_W-1:0] K_085 = 33'sd14260634;
    localparam logic signed [MUL_W-1:0] K_004 = 33'sd671089;
    localparam logic signed [MUL_W-1:0] K_016 = 33'sd2684355;
    localparam logic signed [MUL_W-1:0] K_160 = 33'sd26843546;
    localparam logic signed [MUL_W-1:0] K_020 = 33'sd3355443;
    localparam logic signed [MUL_W-1:0] K_026 = 33'sd4362076;
    localparam logic signed [MUL_W-1:0] K_023 = 33'sd3858760;
    localparam logic signed [MUL_W-1:0] K_022 = 33'sd3690988;
    localparam logic signed [MUL_W-1:0] K_015 = 33'sd2516582;
    localparam logic signed [MUL_W-1:0] K_028 = 33'sd4697620;
    localparam logic signed [MUL_W-1:0] K_024 = 33'sd4026532;
    localparam logic signed [MUL_W-1:0] K_044 = 33'sd7381975;

    typedef enum logic [1:0] {
        MAP_STEM  = 2'd0,
        MAP_MAIN  = 2'd1,
        MAP_LEFT  = 2'd2,
        MAP_RIGHT = 2'd3
    } map_t;

    // Which product of the affine map is being formed.
    typedef enum logic [1:0] {
        TERM_XX = 2'd0,
        TERM_XY = 2'd1,
        TERM_YX = 2'd2,
        TERM_YY = 2'd3
    } term_t;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_MAP  = 11'b000_0000_0010,
        ST_X1   = 11'b000_0000_0100,
        ST_X2   = 11'b000_0000_1000,
        ST_Y1   = 11'b000_0001_0000,
        ST_Y2   = 11'b000_0010_0000,
        ST_PX   = 11'b000_0100_0000,
        ST_PY   = 11'b000_1000_0000,
        ST_SY   = 11'b001_0000_0000,
        ST_VY   = 11'b010_0000_0000,
        ST_OUT  = 11'b100_0000_0000
    } state_t;

    // Coefficient of one product term of the selected affine map.
    function automatic logic signed [MUL_W-1:0] map_coef(input map_t m, input term_t term);
        logic signed [MUL_W-1:0] c;
        begin
            c = '0;
            case (m)
                MAP_STEM:
                begin
                    c = (term == TERM_YY) ? K_016 : '0;
                end
                MAP_MAIN:
                begin
                    case (term)
                        TERM_XX: c = K_085;
                        TERM_XY: c = K_004;
                        TERM_YX: c = -K_004;
                        default: c = K_085;
                    endcase
                end
                MAP_LEFT:
                begin
                    case (term)
                        TERM_XX: c = K_020;
                        TERM_XY: c = -K_026;
                        TERM_YX: c = K_023;
                        default: c = K_022;
                    endcase
                end
                default:
                begin
                    case (term)
                        TERM_XX: c = -K_015;
                        TERM_XY: c = K_028;
                        TERM_YX: c = K_026;
                        default: c = K_024;
                    endcase
                end
            endcase
            return c;
        end
    endfunction

    // Constant term added to the new y of the selected map.
    function automatic logic signed [MUL_W-1:0] map_y_const(input map_t m);
        logic signed [MUL_W-1:0] c;
        begin
            case (m)
                MAP_STEM:  c = '0;
                MAP_MAIN:  c = K_160;
                MAP_LEFT:  c = K_160;
                default:   c = K_044;
            endcase
            return c;
        end
    endfunction

endpackage

// File: rtl/fpg_mul.sv
// Shared signed multiplier of the fern point generator, one registered product.
// Depends on fpg_pkg for the operand and product widths.
module fpg_mul
    import fpg_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [MUL_W-1:0]   a,
    input  logic signed [MUL_W-1:0]   b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [2*MUL_W-1:0] full;
    logic signed [PROD_W-1:0]  prod_reg;

    assign full = a * b;
    assign prod = prod_reg;

    // Every value formed here fits in 64 signed bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full[PROD_W-1:0];
        end
    end

endmodule

// File: rtl/fern_point_generator.sv
// Top level of the fern point generator: sequencer, point state and projection.
// Depends on fpg_pkg and instantiates the shared multiplier fpg_mul.
//
//  Channel   Signals                                   Direction  Transaction
//  -------   ---------------------------------------   ---------  ---------------------------
//  in        in_valid, in_stall, restart               into       one tick of the generator
//  out       out_valid, out_stall, pixel_x, pixel_y,   out of     one generated fern point
//            visible, color_index, map_used
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  into       one register write
//
// A tick runs from acceptance through the sequencer steps to the result register, and
// the next is accepted no sooner than the cycle after that load. The single shared
// 33x33 multiplier is used eight times per tick (generator, four map products, two
// projections, colour reciprocal), and the sequencer walks those steps in order.
// Reset clears the sequencer, the generator, the point and the registers to their
// defaults. While a tick is in flight in_stall is high. A finished result waits in
// the output register while out_stall is high; the sequencer holds in its last step
// until that register is free. Configuration writes are always taken.

module fern_point_generator
    import fpg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600,
    parameter int COLOR_STEPS   = 64
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y,
    output logic               visible,
    output logic [5:0]         color_index,
    output logic [1:0]         map_used,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // The colour index is an integer below 1281 in magnitude. It is moved to a
    // nonnegative value by a multiple of COLOR_STEPS and reduced by a reciprocal.
    localparam int COLOR_BIAS = COLOR_STEPS * ((2048 + COLOR_STEPS - 1) / COLOR_STEPS);
    localparam int COLOR_RECIP = ((1 << 24) + COLOR_STEPS - 1) / COLOR_STEPS;

    state_t state_reg, state_next;

    logic [30:0]        scale_reg;
    logic signed [31:0] x_offset_reg;
    logic signed [31:0] y_offset_reg;

    logic [30:0]        lcg_reg;
    logic signed [31:0] point_x_reg;
    logic signed [31:0] point_y_reg;
    logic signed [31:0] nx_reg;
    map_t               map_reg;

    logic signed [63:0] acc_reg;
    logic signed [15:0] sx_reg;
    logic [11:0]        bias_reg;

    logic               out_valid_reg;
    logic signed [15:0] sx_out_reg;
    logic signed [15:0] sy_out_reg;
    logic               vis_out_reg;
    logic [5:0]         color_out_reg;
    logic [1:0]         map_out_reg;

    logic                      in_accept;
    logic                      out_free;
    logic                      mul_en;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic [30:0]        lcg_seed;
    logic [30:0]        lcg_new;
    map_t               map_new;
    logic signed [39:0] rnd;
    logic signed [40:0] ny_sum;
    logic signed [31:0] nx_sat;
    logic signed [31:0] ny_sat;
    logic signed [35:0] py_times10;
    logic signed [12:0] color_t;
    logic [11:0]        color_biased;
    logic [11:0]        color_q;
    logic [20:0]        color_qc;
    logic [11:0]        color_rem;
    logic signed [15:0] sy_val;
    logic               vis_val;

    // Truncating divide by 2^40 toward zero, then saturate to 16 bits.
    function automatic logic signed [15:0] trunc_sat16(input logic signed [63:0] v);
        logic signed [24:0] q;
        begin
            q = {v[63], v[63:40]} + 25'(v[63] && (|v[39:0]));
            if (q > 25'sd32767)
            begin
                return 16'sh7fff;
            end
            else if (q < -25'sd32768)
            begin
                return 16'sh8000;
            end
            return q[15:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        begin
            if (v > 41'sd2147483647)
            begin
                return 32'sh7fffffff;
            end
            else if (v < -41'sd2147483648)
            begin
                return 32'sh80000000;
            end
            return v[31:0];
        end
    endfunction

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign pixel_x     = sx_out_reg;
    assign pixel_y     = sy_out_reg;
    assign visible     = vis_out_reg;
    assign color_index = color_out_reg;
    assign map_used    = map_out_reg;

    // Generator step and map choice.
    assign lcg_seed = (lcg_reg == '0) ? LCG_SEED : lcg_reg;
    assign lcg_new  = prod[30:0] + LCG_ADD;

    always_comb
    begin
        if (lcg_new < TH_STEM)
        begin
            map_new = MAP_STEM;
        end
        else if (lcg_new < TH_MAIN)
        begin
            map_new = MAP_MAIN;
        end
        else if (lcg_new < TH_LEFT)
        begin
            map_new = MAP_LEFT;
        end
        else
        begin
            map_new = MAP_RIGHT;
        end
    end

    // Round half up to Q8.24; the new y also gets the map's constant term.
    assign rnd    = 40'((acc_reg + 64'sd8388608) >>> 24);
    assign nx_sat = sat32(41'(rnd));
    assign ny_sum = 41'(rnd) + 41'(map_y_const(map_reg));
    assign ny_sat = sat32(ny_sum);

    // Colour: trunc(y * 10) reduced modulo COLOR_STEPS into 0..COLOR_STEPS-1.
    assign py_times10   = (36'(point_y_reg) <<< 3) + (36'(point_y_reg) <<< 1);
    assign color_t      = {py_times10[35], py_times10[35:24]}
                          + 13'(py_times10[35] && (|py_times10[23:0]));
    assign color_biased = 12'(color_t + 13'(COLOR_BIAS));
    assign color_q      = prod[35:24];
    assign color_qc     = 21'(color_q) * 21'(COLOR_STEPS);
    assign color_rem    = bias_reg - color_qc[11:0];

    assign sy_val  = trunc_sat16(acc_reg);
    assign vis_val = (sx_reg >= 16'sd0) && (sx_reg < 16'(SCREEN_WIDTH))
                     && (sy_val >= 16'sd0) && (sy_val < 16'(SCREEN_HEIGHT));

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                mul_en = in_accept;
                mul_a  = MUL_W'(lcg_seed);
                mul_b  = MUL_W'(LCG_MUL);
            end
            ST_X1:
            begin
                mul_a = map_coef(map_reg, TERM_XX);
                mul_b = MUL_W'(point_x_reg);
            end
            ST_X2:
            begin
                mul_a = map_coef(map_reg, TERM_XY);
                mul_b = MUL_W'(point_y_reg);
            end
            ST_Y1:
            begin
                mul_a = map_coef(map_reg, TERM_YX);
                mul_b = MUL_W'(point_x_reg);
            end
            ST_Y2:
            begin
                mul_a = map_coef(map_reg, TERM_YY);
                mul_b = MUL_W'(point_y_reg);
            end
            ST_PX:
            begin
                mul_a = MUL_W'(nx_reg);
                mul_b = MUL_W'(scale_reg);
            end
            ST_SY:
            begin
                mul_a = MUL_W'(point_y_reg);
                mul_b = MUL_W'(scale_reg);
            end
            ST_VY:
            begin
                mul_a = MUL_W'(bias_reg);
                mul_b = MUL_W'(COLOR_RECIP);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    fpg_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: state_next = in_accept ? ST_MAP : ST_IDLE;
            ST_MAP:  state_next = ST_X1;
            ST_X1:   state_next = ST_X2;
            ST_X2:   state_next = ST_Y1;
            ST_Y1:   state_next = ST_Y2;
            ST_Y2:   state_next = ST_PX;
            ST_PX:   state_next = ST_PY;
            ST_PY:   state_next = ST_SY;
            ST_SY:   state_next = ST_VY;
            ST_VY:   state_next = ST_OUT;
            ST_OUT:  state_next = out_free ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scale_reg     <= SCALE_RESET;
            x_offset_reg  <= X_OFFSET_RESET;
            y_offset_reg  <= Y_OFFSET_RESET;
            lcg_reg       <= '0;
            point_x_reg   <= '0;
            point_y_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCALE:    scale_reg    <= cfg_data[30:0];
                    CFG_X_OFFSET: x_offset_reg <= cfg_data;
                    CFG_Y_OFFSET: y_offset_reg <= cfg_data;
                    default:      ;
                endcase
            end

            if (in_accept && restart)
            begin
                point_x_reg <= '0;
                point_y_reg <= '0;
            end
            if (state_reg == ST_MAP)
            begin
                lcg_reg <= lcg_new;
            end
            if (state_reg == ST_PX)
            begin
                point_x_reg <= nx_reg;
            end
            if (state_reg == ST_PY)
            begin
                point_y_reg <= ny_sat;
            end

            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers; the sequencer orders their use, so they need no reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_MAP:
            begin
                map_reg <= map_new;
            end
            ST_X2:
            begin
                acc_reg <= prod;
            end
            ST_Y1:
            begin
                acc_reg <= acc_reg + prod;
            end
            ST_Y2:
            begin
                nx_reg  <= nx_sat;
                acc_reg <= prod;
            end
            ST_PX:
            begin
                acc_reg <= acc_reg + prod;
            end
            ST_PY:
            begin
                acc_reg <= prod + (64'(x_offset_reg) <<< 24);
            end
            ST_SY:
            begin
                sx_reg   <= trunc_sat16(acc_reg);
                bias_reg <= color_biased;
            end
            ST_VY:
            begin
                acc_reg <= (64'(SCREEN_HEIGHT) <<< 40) - prod - (64'(y_offset_reg) <<< 24);
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    sx_out_reg    <= sx_reg;
                    sy_out_reg    <= sy_val;
                    vis_out_reg   <= vis_val;
                    color_out_reg <= vis_val ? color_rem[5:0] : 6'd0;
                    map_out_reg   <= map_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The sequencer is always in exactly one state.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    // An accepted tick starts the generator step in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_MAP)
        else $error("accepted tick did not start the sequence");

    // A result register is loaded only from the final step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result appeared outside the final step");

    // A point off screen carries colour index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !vis_out_reg |-> color_out_reg == 6'd0)
        else $error("invisible point has a nonzero colour index");

    // A visible point lies inside the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && vis_out_reg |-> sx_out_reg >= 16'sd0
            && sx_out_reg < 16'(SCREEN_WIDTH) && sy_out_reg >= 16'sd0
            && sy_out_reg < 16'(SCREEN_HEIGHT))
        else $error("visible point lies off screen");

endmodule
